[hdl/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hdl/d2i_pkg.sv]
package d2i_pkg;

  localparam int unsigned FracBits = 52;
  localparam logic [10:0] ExpBias = 11'd1023;
  localparam logic [10:0] ExpMax = 11'h7FF;

  localparam logic [1:0] ModeSigned = 2'd0;
  localparam logic [1:0] ModeUnsigned = 2'd1;
  localparam logic [1:0] ModeTrunc = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRAP = 2'd0,
    KIND_TRUNC = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [63:0] bits;
    logic        wzero;
    logic        tpass;
    logic        tsign;
    logic [6:0]  unb;
  } dec_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        sign;
    logic [31:0] mag;
    logic [63:0] tres;
  } shf_t;

endpackage

[hdl/double_to_int32_wrap_convert.sv]
// Path: an accepted request passes the decode, shift and finish registers to its result strobe.
// Throughput: one request per cycle; busy is always low.
// Stages: field decode, shift and mask, sign and result select.
// Reset: synchronous active-low rst_n clears all valid bits in the pipeline.
// The receiver cannot stall, so results leave on out_valid unconditionally.
`include "assert_macros.svh"
module double_to_int32_wrap_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  input  logic [1:0]  in_mode,
  output logic        out_valid,
  output logic [63:0] out_result_bits
);

  d2i_pkg::dec_t dec_r;
  d2i_pkg::shf_t shf_r;

  assign busy = 1'b0;

  d2i_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (start),
    .in_value_bits(in_value_bits),
    .in_mode      (in_mode),
    .dec_r        (dec_r)
  );

  d2i_shift u_shift (
    .clk  (clk),
    .rst_n(rst_n),
    .dec_r(dec_r),
    .shf_r(shf_r)
  );

  d2i_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .shf_r    (shf_r),
    .out_vld_r(out_valid),
    .out_res_r(out_result_bits)
  );

  `ASSERT_NEXT(a_req_reaches_shift, clk, rst_n, dec_r.valid, shf_r.valid)
  `ASSERT_NEXT(a_shift_reaches_out, clk, rst_n, shf_r.valid, out_valid)
  `ASSERT_NEXT(a_wrap_upper_zero, clk, rst_n,
               shf_r.valid && (shf_r.kind == d2i_pkg::KIND_WRAP),
               out_result_bits[63:32] == 32'd0)

endmodule

[hdl/d2i_decode.sv]
module d2i_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [63:0]       in_value_bits,
  input  logic [1:0]        in_mode,
  output d2i_pkg::dec_t     dec_r
);

  d2i_pkg::dec_t dec_nxt;
  logic [10:0] expo;
  logic [10:0] unb_full;

  always_comb begin
    expo = in_value_bits[62:52];
    unb_full = expo - d2i_pkg::ExpBias;
    dec_nxt = '0;
    dec_nxt.valid = in_vld;
    dec_nxt.bits = in_value_bits;
    dec_nxt.unb = unb_full[6:0];
    case (in_mode)
      d2i_pkg::ModeSigned, d2i_pkg::ModeUnsigned: begin
        dec_nxt.kind = d2i_pkg::KIND_WRAP;
        dec_nxt.wzero = (expo == d2i_pkg::ExpMax) || (expo < d2i_pkg::ExpBias)
                        || (unb_full >= 11'd84);
      end
      d2i_pkg::ModeTrunc: begin
        dec_nxt.kind = d2i_pkg::KIND_TRUNC;
        dec_nxt.tpass = (expo == d2i_pkg::ExpMax) || (unb_full >= 11'd52)
                        && (expo >= d2i_pkg::ExpBias);
        dec_nxt.tsign = (expo < d2i_pkg::ExpBias);
        if ((expo == d2i_pkg::ExpMax) && (in_value_bits[51:0] != '0)) begin
          dec_nxt.kind = d2i_pkg::KIND_ZERO;
        end
      end
      default: begin
        dec_nxt.kind = d2i_pkg::KIND_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r.valid <= dec_nxt.valid;
    end
    dec_r.kind <= dec_nxt.kind;
    dec_r.bits <= dec_nxt.bits;
    dec_r.wzero <= dec_nxt.wzero;
    dec_r.tpass <= dec_nxt.tpass;
    dec_r.tsign <= dec_nxt.tsign;
    dec_r.unb <= dec_nxt.unb;
  end

endmodule

[hdl/d2i_shift.sv]
module d2i_shift (
  input  logic          clk,
  input  logic          rst_n,
  input  d2i_pkg::dec_t dec_r,
  output d2i_pkg::shf_t shf_r
);

  d2i_pkg::shf_t shf_nxt;
  logic [52:0]  mant;
  logic [116:0] wide;
  logic [63:0]  keep;
  logic [5:0]   tsh;

  always_comb begin
    mant = {1'b1, dec_r.bits[51:0]};
    wide = {64'd0, mant} << dec_r.unb;
    tsh = 6'(7'd52 - dec_r.unb);
    keep = ~((64'd1 << tsh) - 64'd1);
    shf_nxt.valid = dec_r.valid;
    shf_nxt.kind = dec_r.kind;
    shf_nxt.sign = dec_r.bits[63];
    shf_nxt.mag = dec_r.wzero ? 32'd0 : wide[83:52];
    if (dec_r.tpass) begin
      shf_nxt.tres = dec_r.bits;
    end else if (dec_r.tsign) begin
      shf_nxt.tres = {dec_r.bits[63], 63'd0};
    end else begin
      shf_nxt.tres = dec_r.bits & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shf_r.valid <= 1'b0;
    end else begin
      shf_r.valid <= shf_nxt.valid;
    end
    shf_r.kind <= shf_nxt.kind;
    shf_r.sign <= shf_nxt.sign;
    shf_r.mag <= shf_nxt.mag;
    shf_r.tres <= shf_nxt.tres;
  end

endmodule

[hdl/d2i_finish.sv]
module d2i_finish (
  input  logic          clk,
  input  logic          rst_n,
  input  d2i_pkg::shf_t shf_r,
  output logic          out_vld_r,
  output logic [63:0]   out_res_r
);

  logic [63:0] res_nxt;
  logic [31:0] neg;

  always_comb begin
    neg = shf_r.sign ? (32'd0 - shf_r.mag) : shf_r.mag;
    case (shf_r.kind)
      d2i_pkg::KIND_WRAP: res_nxt = {32'd0, neg};
      d2i_pkg::KIND_TRUNC: res_nxt = shf_r.tres;
      default: res_nxt = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= shf_r.valid;
    end
    out_res_r <= res_nxt;
  end

endmodule
